[hw/rtl/modinv_pkg.sv]
// shared constants for the modular inverse block
`default_nettype none
package modinv_pkg;
	localparam int WIDTH = 16;
	localparam int CNT_W = $clog2(WIDTH);
	localparam logic [WIDTH-1:0] MODULUS_RESET = WIDTH'(65);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_STEP = 3'b100
	} state_t;
endpackage
`default_nettype wire

[hw/rtl/modular_inverse.sv]
// modular inverse by extended euclid with a shared bit-serial divide and modular multiply
`default_nettype none
// Each word on value starts a run while busy is low; the result appears on inverse and
// found for exactly one cycle with done high and cannot be stalled. Each Euclid step is a
// restoring division, which also accumulates p*q mod modulus one quotient bit per cycle,
// followed by the Euclid update. A zero value or zero modulus answers in the next cycle
// with found clear. The modulus register may only be written while busy is low and no
// result is pending.
module modular_inverse (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          modulus_we,
	input  wire [modinv_pkg::WIDTH-1:0]  modulus,
	input  wire                          start,
	input  wire [modinv_pkg::WIDTH-1:0]  value,
	output logic                         busy,
	output logic                         done,
	output logic [modinv_pkg::WIDTH-1:0] inverse,
	output logic                         found
);
	import modinv_pkg::*;

	state_t             state_q;
	logic [WIDTH-1:0]   mod_q;
	logic [WIDTH-1:0]   b_q;
	logic [WIDTH-1:0]   rem_q;
	logic [WIDTH-1:0]   quo_q;
	logic [WIDTH-1:0]   acc_q;
	logic [WIDTH-1:0]   p_old_q;
	logic [WIDTH-1:0]   p_cur_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic               found_q;
	logic [WIDTH-1:0]   inverse_q;

	// divider step
	logic [WIDTH:0]     rem_shift;
	logic               qbit;
	logic [WIDTH:0]     rem_sub;
	// modular accumulate step
	logic [WIDTH+1:0]   acc_sum;
	logic [WIDTH+1:0]   acc_m1;
	logic [WIDTH+1:0]   acc_m2;
	logic [WIDTH-1:0]   acc_next;
	// p update
	logic [WIDTH:0]     p_diff;
	logic [WIDTH-1:0]   p_new;

	always_comb begin
		rem_shift = {rem_q, quo_q[WIDTH-1]};
		qbit      = rem_shift >= {1'b0, b_q};
		rem_sub   = rem_shift - {1'b0, b_q};

		acc_sum = {1'b0, acc_q, 1'b0} + (qbit ? {2'b00, p_cur_q} : '0);
		acc_m1  = acc_sum - {2'b00, mod_q};
		acc_m2  = acc_sum - {1'b0, mod_q, 1'b0};
		if (acc_sum >= {1'b0, mod_q, 1'b0}) begin
			acc_next = acc_m2[WIDTH-1:0];
		end else if (acc_sum >= {2'b00, mod_q}) begin
			acc_next = acc_m1[WIDTH-1:0];
		end else begin
			acc_next = acc_sum[WIDTH-1:0];
		end

		if (p_old_q >= acc_q) begin
			p_diff = {1'b0, p_old_q} - {1'b0, acc_q};
		end else begin
			p_diff = {1'b0, p_old_q} + {1'b0, mod_q} - {1'b0, acc_q};
		end
		p_new = p_diff[WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MODULUS_RESET;
		end else if (modulus_we) begin
			mod_q <= modulus;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (value == '0 || mod_q == '0) begin
							done_q <= 1'b1;
						end else begin
							cnt_q   <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(WIDTH-1)) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					cnt_q <= '0;
					if (rem_q == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DIV;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					b_q       <= value;
					quo_q     <= mod_q;
					rem_q     <= '0;
					acc_q     <= '0;
					p_old_q   <= '0;
					p_cur_q   <= (mod_q == WIDTH'(1)) ? '0 : WIDTH'(1);
					inverse_q <= '0;
					found_q   <= 1'b0;
				end
			end
			S_DIV: begin
				rem_q <= qbit ? rem_sub[WIDTH-1:0] : rem_shift[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], qbit};
				acc_q <= acc_next;
			end
			S_STEP: begin
				if (rem_q == '0) begin
					found_q   <= b_q == WIDTH'(1);
					inverse_q <= (b_q == WIDTH'(1)) ? p_cur_q : '0;
				end else begin
					p_old_q <= p_cur_q;
					p_cur_q <= p_new;
					quo_q   <= b_q;
					b_q     <= rem_q;
					rem_q   <= '0;
					acc_q   <= '0;
				end
			end
			default: begin
				acc_q <= '0;
			end
		endcase
	end

	assign busy    = state_q != S_IDLE;
	assign done    = done_q;
	assign inverse = inverse_q;
	assign found   = found_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_start_goes: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done) else $error("accepted word dropped");
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start)) else $error("spurious result");
	a_found_inverse: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> inverse == '0) else $error("inverse set without found");
endmodule
`default_nettype wire
